@@ rtl/prqs_pkg.sv @@
package prqs_pkg;

    // Field widths fixed by the item format
    localparam int ID_W      = 6;
    localparam int PRIO_W    = 5;
    localparam int CNT_W     = 7;
    localparam int QUANT_W   = 8;
    localparam int THR_W     = 32;
    localparam int MODE_W    = 2;

    // Default sizing
    localparam int NUM_PRIORITIES_DEF = 32;
    localparam int MAX_THREADS_DEF    = 64;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIMIT = 2'd2;

    localparam logic [QUANT_W-1:0] QUANTUM_RST     = 8'd8;
    localparam logic [THR_W-1:0]   BOOST_THR_RST   = 32'd32;
    localparam logic [PRIO_W-1:0]  BOOST_LIMIT_RST = 5'd3;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ENQ     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PICK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESCHED = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

    // One request beat
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [ID_W-1:0]    thread_id;
        logic               running;
        logic               dead;
        logic [PRIO_W-1:0]  cur_prio;
        logic [PRIO_W-1:0]  base_prio;
        logic [THR_W-1:0]   sleep_ticks;
        logic [QUANT_W-1:0] quantum_used;
    } t_item;

    // One result beat
    typedef struct packed {
        logic [ID_W-1:0]   next_thread;
        logic              next_valid;
        logic              keep_current;
        logic              enqueued;
        logic [PRIO_W-1:0] new_priority;
        logic [CNT_W-1:0]  ready_count;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic rd_tail_q;
        logic set_keep;
        logic enq_wr;
        logic pick_rd;
        logic pick_chk;
        logic pick_wr;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              enq_ok;
        logic              keep_ok;
        logic              running;
        logic              mask_empty;
        logic              head_eq_tail;
        logic              out_free;
    } t_sts;

endpackage

@@ rtl/prqs_ram.sv @@
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/prqs_ctrl.sv @@
module prqs_ctrl
    import prqs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECIDE   = 3'd1;
    localparam logic [2:0] S_ENQ_WR   = 3'd2;
    localparam logic [2:0] S_PICK_RD  = 3'd3;
    localparam logic [2:0] S_PICK_CHK = 3'd4;
    localparam logic [2:0] S_PICK_WR  = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer: one operation step per state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // tail of the target level is fetched in case an enqueue follows
                o_cmd.rd_tail_q = 1'b1;
                case (i_sts.mode)
                    MODE_ENQ: n_state = i_sts.enq_ok ? S_ENQ_WR : S_DONE;
                    MODE_PICK: n_state = S_PICK_RD;
                    MODE_RESCHED: begin
                        if (i_sts.keep_ok) begin
                            o_cmd.set_keep = 1'b1;
                            n_state        = S_DONE;
                        end else if (i_sts.running && i_sts.enq_ok) begin
                            n_state = S_ENQ_WR;
                        end else begin
                            n_state = S_PICK_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ENQ_WR: begin
                o_cmd.enq_wr = 1'b1;
                n_state = (i_sts.mode == MODE_RESCHED) ? S_PICK_RD : S_DONE;
            end
            S_PICK_RD: begin
                o_cmd.pick_rd = 1'b1;
                n_state = i_sts.mask_empty ? S_DONE : S_PICK_CHK;
            end
            S_PICK_CHK: begin
                o_cmd.pick_chk = 1'b1;
                n_state = i_sts.head_eq_tail ? S_DONE : S_PICK_WR;
            end
            S_PICK_WR: begin
                o_cmd.pick_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/prqs_datapath.sv @@
module prqs_datapath
    import prqs_pkg::*;
#(
    parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
    parameter int MAX_THREADS    = MAX_THREADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_item                 i_item,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_result               o_result
);

    // Levels above 31 are never reached
    localparam int NQ  = (NUM_PRIORITIES > 32) ? 32 : NUM_PRIORITIES;
    localparam int QAW = $clog2(NQ);
    localparam int LAW = $clog2(MAX_THREADS);
    localparam logic [PRIO_W-1:0] TOP = PRIO_W'(NQ - 1);

    // Configuration registers
    logic [QUANT_W-1:0] r_quantum;
    logic [THR_W-1:0]   r_boost_thr;
    logic [PRIO_W-1:0]  r_boost_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum     <= QUANTUM_RST;
            r_boost_thr   <= BOOST_THR_RST;
            r_boost_limit <= BOOST_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_QUANTUM:     r_quantum     <= i_cfg_wdata[QUANT_W-1:0];
                REG_BOOST_THR:   r_boost_thr   <= i_cfg_wdata[THR_W-1:0];
                REG_BOOST_LIMIT: r_boost_limit <= i_cfg_wdata[PRIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Captured request
    t_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_item;
        end
    end

    // Queue state
    logic [NQ-1:0]    r_mask;
    logic [CNT_W-1:0] r_count;
    logic [QAW-1:0]   r_p;

    // Working result
    logic [ID_W-1:0]   r_nt;
    logic              r_nv;
    logic              r_keep;
    logic              r_enq;
    logic [PRIO_W-1:0] r_prio;

    // Highest non-empty level
    logic [QAW-1:0] hr;
    logic           mask_empty;

    always_comb begin
        hr = '0;
        for (int i = 0; i < NQ; i++) begin
            if (r_mask[i]) begin
                hr = QAW'(i);
            end
        end
    end

    assign mask_empty = (r_mask == '0);

    // Priority adjustment: boost after a long sleep, else decay toward base
    logic [PRIO_W:0]   lim;
    logic [PRIO_W-1:0] adj;
    logic [PRIO_W-1:0] q;
    logic [QAW-1:0]    q_addr;

    always_comb begin
        lim = {1'b0, r_in.base_prio} + {1'b0, r_boost_limit};
        if (lim > {1'b0, TOP}) begin
            lim = {1'b0, TOP};
        end
        adj = r_in.cur_prio;
        if (r_in.sleep_ticks > r_boost_thr) begin
            if ({1'b0, r_in.cur_prio} < lim) begin
                adj = r_in.cur_prio + 1'b1;
            end
        end else if (r_in.cur_prio > r_in.base_prio) begin
            adj = r_in.cur_prio - 1'b1;
        end
        q = (adj > TOP) ? TOP : adj;
    end

    assign q_addr = q[QAW-1:0];

    // Memories
    logic [ID_W-1:0] head_rdata;
    logic [ID_W-1:0] tail_rdata;
    logic [ID_W-1:0] link_rdata;
    logic            q_busy;

    logic            head_we;
    logic [QAW-1:0]  head_waddr;
    logic [ID_W-1:0] head_wdata;
    logic            tail_re;
    logic [QAW-1:0]  tail_raddr;
    logic            link_we;

    assign q_busy = r_mask[q_addr];

    always_comb begin
        head_we    = 1'b0;
        head_waddr = q_addr;
        head_wdata = r_in.thread_id;
        if (i_cmd.enq_wr && !q_busy) begin
            head_we = 1'b1;
        end else if (i_cmd.pick_wr) begin
            head_we    = 1'b1;
            head_waddr = r_p;
            head_wdata = link_rdata;
        end
    end

    assign tail_re    = i_cmd.rd_tail_q || i_cmd.pick_rd;
    assign tail_raddr = i_cmd.pick_rd ? hr : q_addr;
    assign link_we    = i_cmd.enq_wr && q_busy;

    prqs_ram #(.WIDTH(ID_W), .DEPTH(NQ)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (i_cmd.pick_rd),
        .i_raddr (hr),
        .o_rdata (head_rdata)
    );

    prqs_ram #(.WIDTH(ID_W), .DEPTH(NQ)) u_tail_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enq_wr),
        .i_waddr (q_addr),
        .i_wdata (r_in.thread_id),
        .i_re    (tail_re),
        .i_raddr (tail_raddr),
        .o_rdata (tail_rdata)
    );

    prqs_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (LAW'(tail_rdata)),
        .i_wdata (r_in.thread_id),
        .i_re    (i_cmd.pick_chk),
        .i_raddr (LAW'(head_rdata)),
        .o_rdata (link_rdata)
    );

    // Queue control state and working result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.enq_wr) begin
                r_mask[q_addr] <= 1'b1;
                if (r_count != CNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.pick_chk) begin
                if (head_rdata == tail_rdata) begin
                    r_mask[r_p] <= 1'b0;
                end
                if (r_count != '0) begin
                    r_count <= r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_nt   <= '0;
            r_nv   <= 1'b0;
            r_keep <= 1'b0;
            r_enq  <= 1'b0;
            r_prio <= '0;
        end
        if (i_cmd.set_keep) begin
            r_keep <= 1'b1;
            r_nv   <= 1'b1;
            r_nt   <= r_in.thread_id;
        end
        if (i_cmd.enq_wr) begin
            r_enq  <= 1'b1;
            r_prio <= q;
        end
        if (i_cmd.pick_rd) begin
            r_p <= hr;
        end
        if (i_cmd.pick_chk) begin
            r_nv <= 1'b1;
            r_nt <= head_rdata;
        end
    end

    // Output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result.next_thread  <= r_nt;
            o_result.next_valid   <= r_nv;
            o_result.keep_current <= r_keep;
            o_result.enqueued     <= r_enq;
            o_result.new_priority <= r_prio;
            o_result.ready_count  <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;

    // Status to the controller
    assign o_sts.mode         = r_in.mode;
    assign o_sts.enq_ok       = !r_in.dead && (32'(r_in.thread_id) < MAX_THREADS);
    assign o_sts.keep_ok      = r_in.running
                                && (mask_empty || (PRIO_W'(hr) <= r_in.cur_prio))
                                && (r_in.quantum_used < r_quantum);
    assign o_sts.running      = r_in.running;
    assign o_sts.mask_empty   = mask_empty;
    assign o_sts.head_eq_tail = (head_rdata == tail_rdata);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

endmodule

@@ rtl/priority_ready_queue_scheduler_core.sv @@
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata request fields, tuser mode
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata thread/prio/count, tuser flags
// cfg       in   i_cfg_we (no wait)            i_cfg_addr, i_cfg_wdata
//
// One request at a time, taken in S_IDLE; each passes S_DECIDE and loads the result in
// S_DONE. A kept thread, a dead enqueue or the unused mode go straight to S_DONE, an
// enqueue via S_ENQ_WR, a pick via S_PICK_RD, S_PICK_CHK and S_PICK_WR (the last two as needed)
// and a requeueing reschedule via S_ENQ_WR and the pick, over the head, tail and link RAMs.
// Reset is synchronous and active low; it empties all levels and zeroes the ready count.
// A waiting result stalls the engine only at the end of the following request beat.
module priority_ready_queue_scheduler_core
    import prqs_pkg::*;
#(
    parameter int NUM_PRIORITIES = NUM_PRIORITIES_DEF,
    parameter int MAX_THREADS    = MAX_THREADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // thread_id[5:0], thread_running[6], thread_dead[7], current_priority[12:8],
    // base_priority[17:13], sleep_ticks[49:18], quantum_used[57:50], zero[63:58]
    input  logic [63:0]           s_axis_tdata,
    // mode[1:0]
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // next_thread[5:0], new_priority[10:6], ready_count[17:11], zero[23:18]
    output logic [23:0]           m_axis_tdata,
    // next_valid[0], keep_current[1], enqueued[2]
    output logic [2:0]            m_axis_tuser,
    // configuration writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_item   item;
    t_result result;
    t_cmd    cmd;
    t_sts    sts;

    // Unpack request beat
    assign item.mode         = s_axis_tuser;
    assign item.thread_id    = s_axis_tdata[5:0];
    assign item.running      = s_axis_tdata[6];
    assign item.dead         = s_axis_tdata[7];
    assign item.cur_prio     = s_axis_tdata[12:8];
    assign item.base_prio    = s_axis_tdata[17:13];
    assign item.sleep_ticks  = s_axis_tdata[49:18];
    assign item.quantum_used = s_axis_tdata[57:50];

    prqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prqs_datapath #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .MAX_THREADS    (MAX_THREADS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    // Pack result beat
    assign m_axis_tdata = {6'd0, result.ready_count, result.new_priority, result.next_thread};
    assign m_axis_tuser = {result.enqueued, result.keep_current, result.next_valid};

endmodule
